// ----- rtl/sidwf_pkg.sv -----
// Shared types and constants of the stream ID write firewall.
// Used by the front, the back and the top level; depends on nothing.
package sidwf_pkg;

	localparam int TABLE_ENTRIES_D  = 128;
	localparam int STREAM_IDS_D     = 256;
	localparam int CLIENTS_PER_ID_D = 4;

	localparam logic [24:0] MAX_WINDOW = 25'h100_0000;

	localparam logic [1:0] REG_WINDOW_BASE    = 2'd0;
	localparam logic [1:0] REG_WINDOW_SIZE    = 2'd1;
	localparam logic [1:0] REG_CLIENTS_IN_USE = 2'd2;

	localparam logic [1:0] KIND_ACCESS = 2'd0;
	localparam logic [1:0] KIND_MAP    = 2'd1;
	localparam logic [1:0] KIND_LOAD   = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam logic [2:0] ACT_NONE    = 3'd0;
	localparam logic [2:0] ACT_READ    = 3'd1;
	localparam logic [2:0] ACT_WRITE   = 3'd2;
	localparam logic [2:0] ACT_DROP    = 3'd3;
	localparam logic [2:0] ACT_DONE    = 3'd4;

	localparam logic [1:0] VIOL_NONE       = 2'd0;
	localparam logic [1:0] VIOL_UNASSIGNED = 2'd1;
	localparam logic [1:0] VIOL_STOLEN     = 2'd2;

	localparam logic [1:0] MAP_OK   = 2'd0;
	localparam logic [1:0] MAP_OOR  = 2'd1;
	localparam logic [1:0] MAP_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [47:0] address;
		logic        wr_access;
		logic [31:0] write_data;
		logic [7:0]  client_no;
		logic [15:0] stream_id;
		logic [6:0]  table_index;
		logic [23:0] override_offset;
		logic [23:0] security_offset;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [23:0] hw_offset;
		logic [31:0] hw_write_data;
		logic [1:0]  violation;
		logic [1:0]  map_status;
	} out_item_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [1:0]  kind;
		logic        in_win;
		logic        wr;
		logic [23:0] off;
		logic [31:0] wdata;
		logic [7:0]  client;
		logic [15:0] sid;
		logic [6:0]  tidx;
		logic [23:0] ovr;
		logic [23:0] sec;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TAB,
		ST_CNT,
		ST_CNTL,
		ST_LST,
		ST_PUT
	} st_t;

endpackage

// ----- rtl/sidwf_fifo.sv -----
// Small register queue used between front and back and on the result side.
// Depends on nothing.
module sidwf_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
		end
	end

endmodule

// ----- rtl/sidwf_front.sv -----
// Front end: takes items, checks the window and forms the offset.
// Depends on sidwf_pkg.
module sidwf_front (
	input  sidwf_pkg::in_item_t item,
	input  logic [47:0]         base,
	input  logic [24:0]         size,
	output sidwf_pkg::cmd_t     cmd
);
	import sidwf_pkg::*;

	logic [48:0] diff;
	logic [24:0] size_c;

	always_comb begin
		size_c = (size > MAX_WINDOW) ? MAX_WINDOW : size;
		diff   = {1'b0, item.address} - {1'b0, base};

		cmd.kind     = item.kind;
		cmd.in_win   = !diff[48] && (diff[47:0] < {23'd0, size_c});
		cmd.wr       = item.wr_access;
		cmd.off      = diff[23:0];
		cmd.wdata    = item.write_data;
		cmd.client   = item.client_no;
		cmd.sid      = item.stream_id;
		cmd.tidx     = item.table_index;
		cmd.ovr      = item.override_offset;
		cmd.sec      = item.security_offset;
	end

endmodule

// ----- rtl/sidwf_back.sv -----
// Back end: client table search, owner list check and update, result forming.
// Depends on sidwf_pkg.
module sidwf_back #(
	parameter int TABLE_ENTRIES  = sidwf_pkg::TABLE_ENTRIES_D,
	parameter int STREAM_IDS     = sidwf_pkg::STREAM_IDS_D,
	parameter int CLIENTS_PER_ID = sidwf_pkg::CLIENTS_PER_ID_D
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           clients_in_use,
	input  sidwf_pkg::cmd_t      cmd_head,
	input  logic                 cmd_empty,
	output logic                 cmd_pop,
	output sidwf_pkg::out_item_t res,
	input  logic                 res_full,
	output logic                 res_push
);
	import sidwf_pkg::*;

	localparam int IW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int TCW  = $clog2(TABLE_ENTRIES + 1);
	localparam int SIDW = $clog2(STREAM_IDS);
	localparam int CW   = $clog2(CLIENTS_PER_ID + 1);
	localparam int LSTW = $clog2(STREAM_IDS * CLIENTS_PER_ID);

	typedef struct packed {
		logic [23:0] ovr;
		logic [23:0] sec;
		logic [7:0]  cid;
	} tab_ent_t;

	tab_ent_t   tab_mem [TABLE_ENTRIES];
	logic [CW-1:0] cnt_mem [STREAM_IDS];
	logic [7:0] lst_mem [STREAM_IDS * CLIENTS_PER_ID];
	logic [STREAM_IDS-1:0] cnt_vld_q;

	st_t        st_q, st_d;
	cmd_t       cmd_q;
	out_item_t  res_q;
	logic [TCW-1:0] rd_idx_q, n_lim;
	logic       tab_vld_s1;
	tab_ent_t   tab_s1;
	logic [SIDW-1:0] sid_q;
	logic [7:0] who_q;
	logic       is_map_q;
	logic [CW-1:0] cnt_q, j_q, cnt_rd_s1;
	logic       cnt_ok_s1;
	logic       lst_vld_s1;
	logic [7:0] lst_s1;

	logic       tab_we, tab_issue, tab_match, tab_end, hit_ovr, need_own;
	logic       lst_issue, lst_hit, lst_end, map_add;
	logic [7:0] osid;
	logic [LSTW-1:0] lst_rd_addr, lst_wr_addr;
	out_item_t  fast_res;

	assign res   = res_q;
	assign n_lim = (clients_in_use > TABLE_ENTRIES) ? TCW'(TABLE_ENTRIES)
		: TCW'(clients_in_use);
	assign osid  = cmd_q.wdata[7:0];
	assign lst_rd_addr = LSTW'(32'(sid_q) * CLIENTS_PER_ID + 32'(j_q));
	assign lst_wr_addr = LSTW'(32'(sid_q) * CLIENTS_PER_ID + 32'(cnt_q));

	// control outputs
	always_comb begin
		cmd_pop   = (st_q == ST_IDLE) && !cmd_empty;
		res_push  = (st_q == ST_PUT) && !res_full;
		tab_we    = cmd_pop && (cmd_head.kind == KIND_LOAD)
			&& (32'(cmd_head.tidx) < TABLE_ENTRIES);
		tab_issue = (st_q == ST_TAB) && (rd_idx_q < n_lim);
		tab_match = tab_vld_s1 && (tab_s1.ovr == cmd_q.off || tab_s1.sec == cmd_q.off);
		tab_end   = (st_q == ST_TAB) && (tab_match || (!tab_issue && !tab_vld_s1));
		hit_ovr   = tab_match && (tab_s1.ovr == cmd_q.off);
		need_own  = tab_end && hit_ovr && (osid != 8'd0) && (32'(osid) < STREAM_IDS);
		lst_issue = (st_q == ST_LST) && (j_q < cnt_q);
		lst_hit   = lst_vld_s1 && (lst_s1 == who_q);
		lst_end   = (st_q == ST_LST) && (lst_hit || (!lst_issue && !lst_vld_s1));
		map_add   = lst_end && !lst_hit && is_map_q && (32'(cnt_q) < CLIENTS_PER_ID);
	end

	// result for items that need no search
	always_comb begin
		fast_res = '0;
		case (cmd_head.kind)
			KIND_ACCESS: begin
				if (cmd_head.in_win) begin
					fast_res.hw_offset = cmd_head.off;
					fast_res.action    = cmd_head.wr ? ACT_WRITE : ACT_READ;
					fast_res.hw_write_data = cmd_head.wr ? cmd_head.wdata : 32'd0;
				end
			end
			KIND_MAP: begin
				fast_res.action     = ACT_DONE;
				fast_res.map_status = (32'(cmd_head.sid) >= STREAM_IDS) ? MAP_OOR : MAP_OK;
			end
			KIND_LOAD: fast_res.action = ACT_DONE;
			default:   fast_res = '0;
		endcase
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (!cmd_empty) begin
					if (cmd_head.kind == KIND_ACCESS && cmd_head.in_win && cmd_head.wr)
						st_d = ST_TAB;
					else if (cmd_head.kind == KIND_MAP && 32'(cmd_head.sid) < STREAM_IDS)
						st_d = ST_CNT;
					else
						st_d = ST_PUT;
				end
			end
			ST_TAB:  if (tab_end) st_d = need_own ? ST_CNT : ST_PUT;
			ST_CNT:  st_d = ST_CNTL;
			ST_CNTL: st_d = ST_LST;
			ST_LST:  if (lst_end) st_d = ST_PUT;
			ST_PUT:  if (!res_full) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (tab_we) begin
			tab_mem[IW'(cmd_head.tidx)] <= '{cmd_head.ovr, cmd_head.sec, cmd_head.client};
		end
		tab_s1 <= tab_mem[rd_idx_q[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (map_add) begin
			cnt_mem[sid_q] <= cnt_q + 1'b1;
		end
		cnt_rd_s1 <= cnt_mem[sid_q];
	end

	always_ff @(posedge clk) begin
		if (map_add) begin
			lst_mem[lst_wr_addr] <= who_q;
		end
		lst_s1 <= lst_mem[lst_rd_addr];
	end

	// datapath
	always_ff @(posedge clk) begin
		cnt_ok_s1 <= cnt_vld_q[sid_q];
		if (cmd_pop) begin
			cmd_q    <= cmd_head;
			res_q    <= fast_res;
			sid_q    <= cmd_head.sid[SIDW-1:0];
			who_q    <= cmd_head.client;
			is_map_q <= (cmd_head.kind == KIND_MAP);
			rd_idx_q <= '0;
		end
		if (tab_issue) begin
			rd_idx_q <= rd_idx_q + 1'b1;
		end
		if (tab_end) begin
			res_q.hw_offset <= cmd_q.off;
			if (hit_ovr && !need_own && osid != 8'd0) begin
				res_q.action        <= ACT_DROP;
				res_q.violation     <= VIOL_UNASSIGNED;
				res_q.hw_write_data <= '0;
			end else begin
				res_q.action        <= ACT_WRITE;
				res_q.hw_write_data <= cmd_q.wdata;
			end
			sid_q <= osid[SIDW-1:0];
			who_q <= tab_s1.cid;
		end
		if (st_q == ST_CNTL) begin
			cnt_q <= cnt_ok_s1 ? cnt_rd_s1 : '0;
			j_q   <= '0;
		end
		if (lst_issue) begin
			j_q <= j_q + 1'b1;
		end
		if (lst_end) begin
			if (is_map_q) begin
				res_q.map_status <= (!lst_hit && 32'(cnt_q) >= CLIENTS_PER_ID)
					? MAP_FULL : MAP_OK;
			end else if (lst_hit) begin
				res_q.action        <= ACT_WRITE;
				res_q.hw_write_data <= cmd_q.wdata;
			end else begin
				res_q.action        <= ACT_DROP;
				res_q.hw_write_data <= '0;
				res_q.violation     <= (cnt_q == '0) ? VIOL_UNASSIGNED : VIOL_STOLEN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			tab_vld_s1 <= 1'b0;
			lst_vld_s1 <= 1'b0;
			cnt_vld_q  <= '0;
		end else begin
			st_q       <= st_d;
			tab_vld_s1 <= tab_issue && !tab_end;
			lst_vld_s1 <= lst_issue && !lst_end;
			if (map_add) begin
				cnt_vld_q[sid_q] <= 1'b1;
			end
		end
	end

endmodule

// ----- rtl/stream_id_write_firewall_unit.sv -----
// Top level of the stream ID write firewall: configuration registers, queues,
// front and back. Depends on sidwf_pkg, sidwf_fifo, sidwf_front, sidwf_back.
//
// Items enter on push/full (transfer when push and !full) as one in_item_t.
// Results leave on empty/pop (transfer when pop and !empty) as one out_item_t,
// exactly one per item, in order. Configuration is written by cfg_wen with
// cfg_index selecting window base, window size or clients in use; the user
// must write it only while no item is in flight, which the block does not
// enforce. Front: window check and offset, into a two-deep queue. Back: one
// item at a time. Loads, reads, unused kinds and accesses needing no search
// go from the pop to the result state; the next item is taken after the push.
// A write inside the window scans the client table at one entry per cycle,
// over clients_in_use entries until a match; an override hit with an owner
// ID in range, or a mapping, then reads the owner count and scans the list.
// Reset clears configuration registers, the back's state, queues and owner
// counts (per-ID valid flags); the client table and owner lists hold nothing
// until written. A stalled receiver fills the two-deep result queue, then the
// back stops, then the command queue fills and full rises.
module stream_id_write_firewall_unit #(
	parameter int TABLE_ENTRIES  = sidwf_pkg::TABLE_ENTRIES_D,
	parameter int STREAM_IDS     = sidwf_pkg::STREAM_IDS_D,
	parameter int CLIENTS_PER_ID = sidwf_pkg::CLIENTS_PER_ID_D
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  sidwf_pkg::in_item_t  req,
	output logic                 full,
	input  logic                 pop,
	output sidwf_pkg::out_item_t rsp,
	output logic                 empty,
	input  logic                 cfg_wen,
	input  logic [1:0]           cfg_index,
	input  logic [47:0]          cfg_data
);
	import sidwf_pkg::*;

	localparam int CMD_W = $bits(cmd_t);
	localparam int RES_W = $bits(out_item_t);

	logic [47:0] base_q;
	logic [24:0] size_q;
	logic [7:0]  ciu_q;

	cmd_t       cmd_in, cmd_head;
	out_item_t  res;
	logic       cmd_empty, cmd_pop, res_full, res_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			size_q <= '0;
			ciu_q  <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_WINDOW_BASE:    base_q <= cfg_data;
				REG_WINDOW_SIZE:    size_q <= cfg_data[24:0];
				REG_CLIENTS_IN_USE: ciu_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	sidwf_front u_front (
		.item (req),
		.base (base_q),
		.size (size_q),
		.cmd  (cmd_in)
	);

	sidwf_fifo #(.W(CMD_W), .DEPTH(2)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.dout   (cmd_head),
		.empty  (cmd_empty)
	);

	sidwf_back #(
		.TABLE_ENTRIES  (TABLE_ENTRIES),
		.STREAM_IDS     (STREAM_IDS),
		.CLIENTS_PER_ID (CLIENTS_PER_ID)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.clients_in_use (ciu_q),
		.cmd_head       (cmd_head),
		.cmd_empty      (cmd_empty),
		.cmd_pop        (cmd_pop),
		.res            (res),
		.res_full       (res_full),
		.res_push       (res_push)
	);

	sidwf_fifo #(.W(RES_W), .DEPTH(2)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res),
		.full   (res_full),
		.pop    (pop),
		.dout   (rsp),
		.empty  (empty)
	);

endmodule
